@@ hw/rtl/ssc_pkg.sv @@
`default_nettype none

package ssc_pkg;

	// Characters the scanner reacts to.
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LSQUARE   = 8'h5B;
	localparam logic [7:0] CH_RSQUARE   = 8'h5D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	// Defaults of the top-level parameters.
	localparam int unsigned DEF_MAX_NESTING = 255;
	localparam int unsigned DEF_OFFSET_BITS = 20;
	localparam int unsigned DEF_MAX_ENTRIES = 255;

	// Depth of the command queue between scanner and emitter.
	localparam int unsigned CMD_DEPTH = 2;

	// Number of offset-range fields carried in one command.
	localparam int unsigned CMD_RANGES = 6;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2
	} quote_t;

	// Which results one accepted byte gives rise to.
	typedef struct packed {
		logic has_split;
		logic has_final;
		logic mismatch;
	} cmd_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssc_cmd_fifo.sv @@
`default_nettype none

module ssc_cmd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	import ssc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ssc_front.sv @@
`default_nettype none

module ssc_front #(
	parameter int unsigned MAX_NESTING = 255,
	parameter int unsigned OFFSET_BITS = 20,
	parameter int unsigned MAX_ENTRIES = 255
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [7:0]             char_code,
	input  wire logic [OFFSET_BITS-1:0] position,
	input  wire logic                   is_final,
	input  wire logic [7:0]             expected_entries,
	output logic                        cmd_push,
	output ssc_pkg::cmd_flags_t         cmd_flags,
	output logic [OFFSET_BITS:0]        split_start,
	output logic [OFFSET_BITS:0]        split_end,
	output logic [7:0]                  split_num,
	output logic [OFFSET_BITS:0]        fin_start,
	output logic [OFFSET_BITS:0]        fin_end,
	output logic [7:0]                  fin_num,
	output logic [OFFSET_BITS:0]        region_start,
	output logic [OFFSET_BITS:0]        region_end,
	output logic [7:0]                  total_num
);
	import ssc_pkg::*;

	localparam int unsigned RW   = OFFSET_BITS + 1;
	localparam int unsigned NW   = $clog2(MAX_NESTING + 1);
	localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CMPW = (CW > 8) ? CW : 8;
	localparam logic [NW-1:0] NEST_MAX  = NW'(MAX_NESTING);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

	logic          comment_q;
	quote_t        quote_q;
	logic          escape_q;
	logic          prior_q;
	logic [NW-1:0] paren_q;
	logic [NW-1:0] square_q;
	logic          seen_q;
	logic [RW-1:0] first_q;
	logic [RW-1:0] text_end_q;
	logic [CW-1:0] count_q;
	logic [RW-1:0] region_begin_q;
	logic          awaiting_q;

	logic          comment_d;
	quote_t        quote_d;
	logic          escape_d;
	logic          prior_d;
	logic [NW-1:0] paren_d;
	logic [NW-1:0] square_d;
	logic          seen_d;
	logic [RW-1:0] first_d;
	logic [RW-1:0] text_end_d;
	logic [CW-1:0] count_d;
	logic [CW-1:0] count_fin;
	logic [RW-1:0] pos_ext;
	logic [RW-1:0] next_pos;
	logic          splits;
	logic          blank;

	always_comb begin
		comment_d  = comment_q;
		quote_d    = quote_q;
		escape_d   = escape_q;
		prior_d    = prior_q;
		paren_d    = paren_q;
		square_d   = square_q;
		splits     = 1'b0;
		pos_ext    = RW'(position);
		next_pos   = pos_ext + 1'b1;
		blank      = char_code inside {CH_SPACE, [CH_TAB:CH_CR]};

		if (comment_q) begin
			if (prior_q && char_code == CH_SLASH) begin
				comment_d = 1'b0;
				prior_d   = 1'b0;
			end else begin
				prior_d = (char_code == CH_STAR);
			end
		end else if (quote_q != QUOTE_NONE) begin
			if (escape_q) begin
				escape_d = 1'b0;
			end else if (char_code == CH_BACKSLASH) begin
				escape_d = 1'b1;
			end else if ((quote_q == QUOTE_SINGLE && char_code == CH_SQUOTE) ||
			             (quote_q == QUOTE_DOUBLE && char_code == CH_DQUOTE)) begin
				quote_d = QUOTE_NONE;
			end
		end else if (prior_q && char_code == CH_STAR) begin
			comment_d = 1'b1;
			prior_d   = 1'b0;
		end else begin
			prior_d = (char_code == CH_SLASH);
			case (char_code)
				CH_SQUOTE: begin
					quote_d = QUOTE_SINGLE;
				end
				CH_DQUOTE: begin
					quote_d = QUOTE_DOUBLE;
				end
				CH_LPAREN: begin
					if (paren_q < NEST_MAX) paren_d = paren_q + 1'b1;
				end
				CH_RPAREN: begin
					if (paren_q != '0) paren_d = paren_q - 1'b1;
				end
				CH_LSQUARE: begin
					if (square_q < NEST_MAX) square_d = square_q + 1'b1;
				end
				CH_RSQUARE: begin
					if (square_q != '0) square_d = square_q - 1'b1;
				end
				CH_COMMA: begin
					splits = (paren_q == '0) && (square_q == '0);
				end
				default: begin
				end
			endcase
		end
	end

	// Entry bookkeeping: a splitting comma closes the current entry, other
	// non-blank bytes extend it; the final byte then closes what is left.
	always_comb begin
		seen_d      = seen_q;
		first_d     = first_q;
		text_end_d  = text_end_q;
		count_d     = count_q;
		split_start = seen_q ? first_q : pos_ext;
		split_end   = seen_q ? text_end_q : pos_ext;
		if (splits) begin
			if (count_q < COUNT_MAX) count_d = count_q + 1'b1;
			seen_d = 1'b0;
		end else if (!blank) begin
			if (!seen_q) first_d = pos_ext;
			seen_d     = 1'b1;
			text_end_d = next_pos;
		end
		fin_start = seen_d ? first_d : next_pos;
		fin_end   = seen_d ? text_end_d : next_pos;
		count_fin = (count_d < COUNT_MAX) ? count_d + 1'b1 : count_d;
	end

	assign split_num    = 8'(count_q);
	assign fin_num      = 8'(count_d);
	assign total_num    = 8'(count_fin);
	assign region_start = awaiting_q ? pos_ext : region_begin_q;
	assign region_end   = next_pos;

	assign cmd_flags.has_split = splits;
	assign cmd_flags.has_final = is_final;
	assign cmd_flags.mismatch  = (CMPW'(count_fin) != CMPW'(expected_entries));
	assign cmd_push            = accept && (splits || is_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_q      <= 1'b0;
			quote_q        <= QUOTE_NONE;
			escape_q       <= 1'b0;
			prior_q        <= 1'b0;
			paren_q        <= '0;
			square_q       <= '0;
			seen_q         <= 1'b0;
			first_q        <= '0;
			text_end_q     <= '0;
			count_q        <= '0;
			region_begin_q <= '0;
			awaiting_q     <= 1'b1;
		end else if (accept) begin
			if (is_final) begin
				comment_q      <= 1'b0;
				quote_q        <= QUOTE_NONE;
				escape_q       <= 1'b0;
				prior_q        <= 1'b0;
				paren_q        <= '0;
				square_q       <= '0;
				seen_q         <= 1'b0;
				first_q        <= '0;
				text_end_q     <= '0;
				count_q        <= '0;
				region_begin_q <= '0;
				awaiting_q     <= 1'b1;
			end else begin
				comment_q      <= comment_d;
				quote_q        <= quote_d;
				escape_q       <= escape_d;
				prior_q        <= prior_d;
				paren_q        <= paren_d;
				square_q       <= square_d;
				seen_q         <= seen_d;
				first_q        <= first_d;
				text_end_q     <= text_end_d;
				count_q        <= count_d;
				region_begin_q <= region_start;
				awaiting_q     <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ssc_back.sv @@
`default_nettype none

module ssc_back #(
	parameter int unsigned OFFSET_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_empty,
	output logic                      cmd_pop,
	input  wire ssc_pkg::cmd_flags_t  cmd_flags,
	input  wire logic [OFFSET_BITS:0] split_start,
	input  wire logic [OFFSET_BITS:0] split_end,
	input  wire logic [7:0]           split_num,
	input  wire logic [OFFSET_BITS:0] fin_start,
	input  wire logic [OFFSET_BITS:0] fin_end,
	input  wire logic [7:0]           fin_num,
	input  wire logic [OFFSET_BITS:0] region_start,
	input  wire logic [OFFSET_BITS:0] region_end,
	input  wire logic [7:0]           total_num,
	input  wire logic                 pop,
	output logic                      empty,
	output logic [OFFSET_BITS:0]      range_start,
	output logic [OFFSET_BITS:0]      range_end,
	output logic [7:0]                entry_number,
	output logic                      is_summary,
	output logic                      count_mismatch,
	output logic                      last_of_run
);
	import ssc_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST = 3'b001,
		PH_ENTRY = 3'b010,
		PH_SUM   = 3'b100
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   out_valid_q;
	logic   load;
	logic   emit_split;
	logic   emit_sum;
	logic   done;

	assign load       = !cmd_empty && (!out_valid_q || pop);
	assign emit_split = (phase_q == PH_FIRST) && cmd_flags.has_split;
	assign emit_sum   = (phase_q == PH_SUM);
	assign done       = emit_sum || (emit_split && !cmd_flags.has_final);
	assign cmd_pop    = load && done;
	assign empty      = !out_valid_q;

	always_comb begin
		case (phase_q)
			PH_FIRST: begin
				if (emit_split && cmd_flags.has_final) begin
					phase_d = PH_ENTRY;
				end else if (emit_split) begin
					phase_d = PH_FIRST;
				end else begin
					phase_d = PH_SUM;
				end
			end
			PH_ENTRY: begin
				phase_d = PH_SUM;
			end
			PH_SUM: begin
				phase_d = PH_FIRST;
			end
			default: begin
				phase_d = PH_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= phase_d;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_split) begin
				range_start  <= split_start;
				range_end    <= split_end;
				entry_number <= split_num;
			end else if (emit_sum) begin
				range_start  <= region_start;
				range_end    <= region_end;
				entry_number <= total_num;
			end else begin
				range_start  <= fin_start;
				range_end    <= fin_end;
				entry_number <= fin_num;
			end
			is_summary     <= emit_sum;
			count_mismatch <= emit_sum && cmd_flags.mismatch;
			last_of_run    <= done;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/selector_list_comma_splitter.sv @@
// Channel   Handshake          Accepted when        Payload
// ------    ---------          -------------        -------
// input     push / full        push && !full        char_code, position, is_final,
//                                                   expected_entries
// result    empty / pop        pop && !empty        range_start, range_end, entry_number,
//                                                   is_summary, count_mismatch, last_of_run
//
// One byte is taken every cycle while full is low. A byte that causes k results (k is 0
// to 3) keeps the emitter busy for all k of them; the two-entry command queue between the
// scanner and the emitter lets the input run on meanwhile, so full rises only while both
// queue entries are occupied. The first result of a byte passes through the command queue
// and the output register before it is on the ports. The asynchronous reset empties the
// queue and the output register and returns the scanner to its region start.
`default_nettype none

module selector_list_comma_splitter #(
	parameter int unsigned MAX_NESTING = ssc_pkg::DEF_MAX_NESTING,
	parameter int unsigned OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS,
	parameter int unsigned MAX_ENTRIES = ssc_pkg::DEF_MAX_ENTRIES
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             char_code,
	input  wire logic [OFFSET_BITS-1:0] position,
	input  wire logic                   is_final,
	input  wire logic [7:0]             expected_entries,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [OFFSET_BITS:0]        range_start,
	output logic [OFFSET_BITS:0]        range_end,
	output logic [7:0]                  entry_number,
	output logic                        is_summary,
	output logic                        count_mismatch,
	output logic                        last_of_run
);
	import ssc_pkg::*;

	localparam int unsigned RW = OFFSET_BITS + 1;
	// Flags, six offset ranges and three entry numbers.
	localparam int unsigned CMD_W = $bits(cmd_flags_t) + CMD_RANGES * RW + 3 * 8;

	// The front end sees an input transaction whenever the queue has room.
	logic               accept;
	logic               cmd_push;
	logic               cmd_full;
	logic               cmd_empty;
	logic               cmd_pop;
	logic [CMD_W-1:0]   cmd_wdata;
	logic [CMD_W-1:0]   cmd_rdata;

	cmd_flags_t         wr_flags;
	logic [RW-1:0]      wr_split_start;
	logic [RW-1:0]      wr_split_end;
	logic [7:0]         wr_split_num;
	logic [RW-1:0]      wr_fin_start;
	logic [RW-1:0]      wr_fin_end;
	logic [7:0]         wr_fin_num;
	logic [RW-1:0]      wr_region_start;
	logic [RW-1:0]      wr_region_end;
	logic [7:0]         wr_total_num;

	cmd_flags_t         rd_flags;
	logic [RW-1:0]      rd_split_start;
	logic [RW-1:0]      rd_split_end;
	logic [7:0]         rd_split_num;
	logic [RW-1:0]      rd_fin_start;
	logic [RW-1:0]      rd_fin_end;
	logic [7:0]         rd_fin_num;
	logic [RW-1:0]      rd_region_start;
	logic [RW-1:0]      rd_region_end;
	logic [7:0]         rd_total_num;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// The scanner classifies every byte and, where the byte closes an entry or
	// the region, hands one command describing all of its results to the queue.
	ssc_front #(
		.MAX_NESTING (MAX_NESTING),
		.OFFSET_BITS (OFFSET_BITS),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.char_code        (char_code),
		.position         (position),
		.is_final         (is_final),
		.expected_entries (expected_entries),
		.cmd_push         (cmd_push),
		.cmd_flags        (wr_flags),
		.split_start      (wr_split_start),
		.split_end        (wr_split_end),
		.split_num        (wr_split_num),
		.fin_start        (wr_fin_start),
		.fin_end          (wr_fin_end),
		.fin_num          (wr_fin_num),
		.region_start     (wr_region_start),
		.region_end       (wr_region_end),
		.total_num        (wr_total_num)
	);

	assign cmd_wdata = {wr_flags, wr_split_start, wr_split_end, wr_split_num,
	                    wr_fin_start, wr_fin_end, wr_fin_num,
	                    wr_region_start, wr_region_end, wr_total_num};

	ssc_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wdata),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rdata),
		.empty   (cmd_empty)
	);

	assign {rd_flags, rd_split_start, rd_split_end, rd_split_num,
	        rd_fin_start, rd_fin_end, rd_fin_num,
	        rd_region_start, rd_region_end, rd_total_num} = cmd_rdata;

	// The emitter walks each command through its one to three results and
	// keeps the current one in its output register until it is popped.
	ssc_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.cmd_flags      (rd_flags),
		.split_start    (rd_split_start),
		.split_end      (rd_split_end),
		.split_num      (rd_split_num),
		.fin_start      (rd_fin_start),
		.fin_end        (rd_fin_end),
		.fin_num        (rd_fin_num),
		.region_start   (rd_region_start),
		.region_end     (rd_region_end),
		.total_num      (rd_total_num),
		.pop            (pop),
		.empty          (empty),
		.range_start    (range_start),
		.range_end      (range_end),
		.entry_number   (entry_number),
		.is_summary     (is_summary),
		.count_mismatch (count_mismatch),
		.last_of_run    (last_of_run)
	);

	// A summary always ends the run of results of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_summary |-> last_of_run)
		else $error("summary result without last_of_run");

	// The mismatch flag is only ever raised on a summary.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && count_mismatch |-> is_summary)
		else $error("count_mismatch on an entry range");

	// Every queued command carries at least one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (wr_flags.has_split || wr_flags.has_final))
		else $error("empty command pushed into the queue");

	// The emitter only releases a queue entry that is there.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from an empty queue");

endmodule

`default_nettype wire
